>>> hdl/tvm_pkg.sv
// Shared types and codes of the instruction step unit.
package tvm_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned OpW    = 4;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned LenW   = 11;
  localparam int unsigned HkW    = 32;

  typedef enum logic [1:0] {
    KIND_PROG    = 2'd0,
    KIND_EXEC    = 2'd1,
    KIND_REG     = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef enum logic [OpW-1:0] {
    OP_NOP     = 4'd0,
    OP_HALT    = 4'd1,
    OP_LOADIMM = 4'd2,
    OP_LOAD    = 4'd3,
    OP_STORE   = 4'd4,
    OP_DIV     = 4'd5,
    OP_MOD     = 4'd6,
    OP_JUMP    = 4'd7
  } op_e;

  typedef enum logic [1:0] {
    TRAP_NONE     = 2'd0,
    TRAP_DECODE   = 2'd1,
    TRAP_BOUNDS   = 2'd2,
    TRAP_DIVISION = 2'd3
  } trap_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RIDX,
    ST_RDREQ,
    ST_EXEC,
    ST_DIV,
    ST_DFIN,
    ST_EMIT
  } st_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
  } slot_t;

endpackage

>>> hdl/tvm_cmd_if.sv
// Command channel: valid/ready handshake with one request as payload.
interface tvm_cmd_if;
  import tvm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [SlotW-1:0] slot_index;
  logic [OpW-1:0]   op_code;
  logic [WordW-1:0] operand_a;
  logic [WordW-1:0] operand_b;
  logic [WordW-1:0] operand_c;
  logic [WordW-1:0] write_value;

  modport source (output valid, kind, slot_index, op_code, operand_a, operand_b, operand_c,
                  write_value, input ready);
  modport sink (input valid, kind, slot_index, op_code, operand_a, operand_b, operand_c,
                write_value, output ready);
endinterface

>>> hdl/tvm_trace_if.sv
// Trace channel: valid/ready handshake with one trace entry as payload.
interface tvm_trace_if;
  import tvm_pkg::*;
  logic             valid;
  logic             ready;
  logic [SlotW-1:0] trace_pc;
  logic [OpW-1:0]   trace_opcode;
  logic [1:0]       fault_code;
  logic             halted_now;
  logic [HkW-1:0]   housekeeping_count;

  modport source (output valid, trace_pc, trace_opcode, fault_code, halted_now,
                  housekeeping_count, input ready);
  modport sink (input valid, trace_pc, trace_opcode, fault_code, halted_now,
                housekeeping_count, output ready);
endinterface

>>> hdl/tiny_vm_instruction_step_unit.sv
// Instruction step unit: program store, register file and data memory with a sequencer.
//
//   channel   direction  transaction
//   cmd_i     in         program write, execute step, register write, restart
//   trace_o   out        one trace entry per executed step on a running machine
//   cfg       in         program_length write (cfg_we_i, cfg_wdata_i)
//
// A command is taken only in the idle state; non-execute commands leave the unit idle.
// An execute step runs from acceptance to its trace entry through fetch, a byte-wise
// register index reduction, memory reads and write-back. Divide and remainder add the
// bit-serial divider and its write-back.
// Reset clears the control state, and the register file and data memory at once through valid bits.
// A waiting trace entry does not block new commands; a new entry waits until it is taken.
module tiny_vm_instruction_step_unit
  import tvm_pkg::*;
#(
  parameter int unsigned PROGRAM_DEPTH         = 1024,
  parameter int unsigned NUM_REGS              = 16,
  parameter int unsigned DATA_DEPTH            = 256,
  parameter int unsigned HOUSEKEEPING_INTERVAL = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tvm_cmd_if.sink         cmd_i,
  tvm_trace_if.source     trace_o,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i
);

  localparam int unsigned PAW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int unsigned DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned RW  = $clog2(NUM_REGS);
  localparam int unsigned SCW = $clog2(HOUSEKEEPING_INTERVAL + 1);

  // Control state.
  st_e             st_q, st_d;
  logic [LenW-1:0] cfg_q;
  logic [WordW-1:0] pc_q, pc_d;
  logic            halt_q, halt_d;
  logic [SCW-1:0]  sc_q, sc_d;
  logic [HkW-1:0]  hk_q, hk_d;
  logic [2:0]      bcnt_q, bcnt_d;
  logic [5:0]      dcnt_q, dcnt_d;

  // Instruction and step payload.
  slot_t           slot_q, slot_d;
  logic [RW-1:0]   ra_q, rb_q, rc_q, ra_d, rb_d, rc_d;
  logic [SlotW-1:0] tr_pc_q, tr_pc_d;
  logic [OpW-1:0]  tr_op_q, tr_op_d;
  trap_e           tr_trap_q, tr_trap_d;
  logic [WordW-1:0] dq_q, dq_d, rem_q, rem_d, dv_q, dv_d;
  logic            qneg_q, qneg_d, rneg_q, rneg_d;

  // Output register.
  logic            o_valid_q;
  logic [SlotW-1:0] o_pc_q;
  logic [OpW-1:0]  o_op_q;
  trap_e           o_trap_q;
  logic            o_halt_q;
  logic [HkW-1:0]  o_hk_q;
  logic            o_load;

  // Memories.
  slot_t           pm [PROGRAM_DEPTH];
  slot_t           pm_rd_q;
  logic            pm_we;
  logic [PAW-1:0]  pm_waddr;

  logic [WordW-1:0] rf [NUM_REGS];
  logic [WordW-1:0] rf_rb_q, rf_rc_q;
  logic [NUM_REGS-1:0] rf_vld_q;
  logic            rf_vb_q, rf_vc_q;
  logic            rf_we, rf_clr;
  logic [RW-1:0]   rf_waddr;
  logic [WordW-1:0] rf_wdata;

  logic [WordW-1:0] dm [DATA_DEPTH];
  logic [WordW-1:0] dm_rd_q;
  logic [DATA_DEPTH-1:0] dm_vld_q;
  logic            dm_v_q;
  logic            dm_we;
  logic [DAW-1:0]  dm_raddr, dm_waddr;

  logic [WordW-1:0] lhs, rhs, dm_val;
  logic            accept;
  logic            pc_ok;
  logic [SCW-1:0]  sc_inc;
  logic [WordW:0]  rem_sh, diff;
  logic [WordW-1:0] quo_res, rem_res;

  assign accept = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (st_q == ST_IDLE);

  assign lhs    = rf_vb_q ? rf_rb_q : '0;
  assign rhs    = rf_vc_q ? rf_rc_q : '0;
  assign dm_val = dm_v_q ? dm_rd_q : '0;
  assign pc_ok  = (pc_q < WordW'(cfg_q)) && (pc_q < WordW'(PROGRAM_DEPTH));
  assign sc_inc = sc_q + SCW'(1);
  assign dm_raddr = DAW'(slot_q.b);

  assign rem_sh  = {rem_q, dq_q[WordW-1]};
  assign diff    = rem_sh - {1'b0, dv_q};
  assign quo_res = qneg_q ? (WordW'(0) - dq_q) : dq_q;
  assign rem_res = rneg_q ? (WordW'(0) - rem_q) : rem_q;

  function automatic logic addr_ok(input logic [WordW-1:0] v);
    return !v[WordW-1] && (v < WordW'(DATA_DEPTH));
  endfunction

  always_comb begin
    logic [RW:0]  t;
    logic [7:0]   by;
    st_d      = st_q;
    pc_d      = pc_q;
    halt_d    = halt_q;
    sc_d      = sc_q;
    hk_d      = hk_q;
    bcnt_d    = bcnt_q;
    dcnt_d    = dcnt_q;
    slot_d    = slot_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    rc_d      = rc_q;
    tr_pc_d   = tr_pc_q;
    tr_op_d   = tr_op_q;
    tr_trap_d = tr_trap_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    dv_d      = dv_q;
    qneg_d    = qneg_q;
    rneg_d    = rneg_q;
    pm_we     = 1'b0;
    pm_waddr  = PAW'(cmd_i.slot_index);
    rf_we     = 1'b0;
    rf_clr    = 1'b0;
    rf_waddr  = ra_q;
    rf_wdata  = slot_q.b;
    dm_we     = 1'b0;
    dm_waddr  = DAW'(slot_q.a);
    o_load    = 1'b0;
    t         = '0;
    by        = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_e'(cmd_i.kind))
            KIND_PROG: begin
              pm_we = (32'(cmd_i.slot_index) < PROGRAM_DEPTH);
            end
            KIND_REG: begin
              rf_we    = (32'(cmd_i.slot_index) < NUM_REGS);
              rf_waddr = RW'(cmd_i.slot_index);
              rf_wdata = cmd_i.write_value;
            end
            KIND_RESTART: begin
              rf_clr = 1'b1;
              pc_d   = '0;
              halt_d = 1'b0;
              sc_d   = '0;
              hk_d   = '0;
            end
            KIND_EXEC: begin
              // The pc moves during the step, so the trace keeps the one it started at.
              tr_pc_d = pc_q[SlotW-1:0];
              if (!halt_q) begin
                if (pc_ok) begin
                  st_d = ST_FETCH;
                end else begin
                  tr_op_d   = OP_NOP;
                  tr_trap_d = TRAP_DECODE;
                  st_d      = ST_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        slot_d = pm_rd_q;
        tr_op_d = pm_rd_q.op;
        if (sc_inc >= SCW'(HOUSEKEEPING_INTERVAL)) begin
          sc_d = '0;
          hk_d = hk_q + HkW'(1);
        end else begin
          sc_d = sc_inc;
        end
        ra_d   = '0;
        rb_d   = '0;
        rc_d   = '0;
        bcnt_d = '0;
        st_d   = ST_RIDX;
      end
      ST_RIDX: begin
        // Register numbers are the operands modulo NUM_REGS, one byte per cycle, MSB first.
        by = slot_q.a[8*(7-bcnt_q) +: 8];
        for (int i = 7; i >= 0; i--) begin
          t = {ra_d, by[i]};
          if (t >= (RW+1)'(NUM_REGS)) t = t - (RW+1)'(NUM_REGS);
          ra_d = t[RW-1:0];
        end
        by = slot_q.b[8*(7-bcnt_q) +: 8];
        for (int i = 7; i >= 0; i--) begin
          t = {rb_d, by[i]};
          if (t >= (RW+1)'(NUM_REGS)) t = t - (RW+1)'(NUM_REGS);
          rb_d = t[RW-1:0];
        end
        by = slot_q.c[8*(7-bcnt_q) +: 8];
        for (int i = 7; i >= 0; i--) begin
          t = {rc_d, by[i]};
          if (t >= (RW+1)'(NUM_REGS)) t = t - (RW+1)'(NUM_REGS);
          rc_d = t[RW-1:0];
        end
        bcnt_d = bcnt_q + 3'd1;
        if (bcnt_q == 3'd7) st_d = ST_RDREQ;
      end
      ST_RDREQ: begin
        st_d = ST_EXEC;
      end
      ST_EXEC: begin
        tr_trap_d = TRAP_NONE;
        st_d      = ST_EMIT;
        case (slot_q.op)
          OP_NOP: pc_d = pc_q + WordW'(1);
          OP_HALT: begin
            halt_d = 1'b1;
            pc_d   = pc_q + WordW'(1);
          end
          OP_LOADIMM: begin
            rf_we = 1'b1;
            pc_d  = pc_q + WordW'(1);
          end
          OP_LOAD: begin
            if (addr_ok(slot_q.b)) begin
              rf_we    = 1'b1;
              rf_wdata = dm_val;
              pc_d     = pc_q + WordW'(1);
            end else begin
              tr_trap_d = TRAP_DECODE;
            end
          end
          OP_STORE: begin
            if (addr_ok(slot_q.a)) begin
              dm_we = 1'b1;
              pc_d  = pc_q + WordW'(1);
            end else begin
              tr_trap_d = TRAP_BOUNDS;
            end
          end
          OP_DIV, OP_MOD: begin
            if (rhs == '0) begin
              tr_trap_d = TRAP_DIVISION;
            end else begin
              dq_d   = lhs[WordW-1] ? (WordW'(0) - lhs) : lhs;
              dv_d   = rhs[WordW-1] ? (WordW'(0) - rhs) : rhs;
              rem_d  = '0;
              qneg_d = lhs[WordW-1] ^ rhs[WordW-1];
              rneg_d = lhs[WordW-1];
              dcnt_d = '0;
              st_d   = ST_DIV;
            end
          end
          OP_JUMP: pc_d = slot_q.a;
          default: tr_trap_d = TRAP_DECODE;
        endcase
      end
      ST_DIV: begin
        // Restoring divider, one quotient bit per cycle.
        if (!diff[WordW]) begin
          rem_d = diff[WordW-1:0];
          dq_d  = {dq_q[WordW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[WordW-1:0];
          dq_d  = {dq_q[WordW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) st_d = ST_DFIN;
      end
      ST_DFIN: begin
        rf_we    = 1'b1;
        rf_wdata = (slot_q.op == OP_DIV) ? quo_res : rem_res;
        pc_d     = pc_q + WordW'(1);
        st_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!o_valid_q || trace_o.ready) begin
          o_load = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cfg_q     <= '0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
      sc_q      <= '0;
      hk_q      <= '0;
      bcnt_q    <= '0;
      dcnt_q    <= '0;
      o_valid_q <= 1'b0;
      rf_vld_q  <= '0;
      dm_vld_q  <= '0;
    end else begin
      st_q   <= st_d;
      pc_q   <= pc_d;
      halt_q <= halt_d;
      sc_q   <= sc_d;
      hk_q   <= hk_d;
      bcnt_q <= bcnt_d;
      dcnt_q <= dcnt_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (o_load) begin
        o_valid_q <= 1'b1;
      end else if (trace_o.ready) begin
        o_valid_q <= 1'b0;
      end
      if (rf_clr) begin
        rf_vld_q <= '0;
        dm_vld_q <= '0;
      end else begin
        if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
        if (dm_we) dm_vld_q[dm_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    ra_q      <= ra_d;
    rb_q      <= rb_d;
    rc_q      <= rc_d;
    tr_pc_q   <= tr_pc_d;
    tr_op_q   <= tr_op_d;
    tr_trap_q <= tr_trap_d;
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    dv_q      <= dv_d;
    qneg_q    <= qneg_d;
    rneg_q    <= rneg_d;
    rf_vb_q   <= rf_vld_q[rb_q];
    rf_vc_q   <= rf_vld_q[rc_q];
    dm_v_q    <= dm_vld_q[dm_raddr];
    if (o_load) begin
      o_pc_q   <= tr_pc_q;
      o_op_q   <= tr_op_q;
      o_trap_q <= tr_trap_q;
      o_halt_q <= halt_q;
      o_hk_q   <= hk_q;
    end
  end

  // Program store.
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pm[pm_waddr] <= '{op: cmd_i.op_code, a: cmd_i.operand_a, b: cmd_i.operand_b,
                        c: cmd_i.operand_c};
    end
    pm_rd_q <= pm[PAW'(pc_q)];
  end

  // Register file: one write port, two read ports.
  always_ff @(posedge clk_i) begin
    if (rf_we) rf[rf_waddr] <= rf_wdata;
    rf_rb_q <= rf[rb_q];
    rf_rc_q <= rf[rc_q];
  end

  // Data memory.
  always_ff @(posedge clk_i) begin
    if (dm_we) dm[dm_waddr] <= lhs;
    dm_rd_q <= dm[dm_raddr];
  end

  assign trace_o.valid              = o_valid_q;
  assign trace_o.trace_pc           = o_pc_q;
  assign trace_o.trace_opcode       = o_op_q;
  assign trace_o.fault_code         = o_trap_q;
  assign trace_o.halted_now         = o_halt_q;
  assign trace_o.housekeeping_count = o_hk_q;

endmodule

>>> hdl/tvm_chk.sv
// Port checker for the instruction step unit and its bind.
module tvm_chk
  import tvm_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cmd_valid_i,
  input logic           cmd_ready_i,
  input logic [1:0]     cmd_kind_i,
  input logic           tr_valid_i,
  input logic           tr_ready_i,
  input logic [OpW-1:0] tr_op_i,
  input logic [1:0]     tr_trap_i,
  input logic           tr_halt_i
);

  // A stalled trace transaction holds its payload.
  a_tr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_valid_i && !tr_ready_i |=> tr_valid_i && $stable(tr_op_i) && $stable(tr_trap_i))
    else $error("trace payload changed while stalled");

  // Commands other than execute never produce a new trace entry.
  a_no_trace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && cmd_kind_i != KIND_EXEC |=> !$rose(tr_valid_i))
    else $error("trace entry after a non-execute command");

  // A restart leaves the unit ready again in the cycle after it is taken.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && cmd_kind_i == KIND_RESTART |=> cmd_ready_i)
    else $error("unit busy after restart");

  // Only a clean halt leaves the machine halted.
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_valid_i && tr_halt_i |-> tr_op_i == OP_HALT && tr_trap_i == TRAP_NONE)
    else $error("halted entry without a halt instruction");

  // A division fault comes only from divide or remainder.
  a_divtrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_valid_i && tr_trap_i == TRAP_DIVISION |-> tr_op_i == OP_DIV || tr_op_i == OP_MOD)
    else $error("division fault on another opcode");

endmodule

bind tiny_vm_instruction_step_unit tvm_chk u_tvm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .cmd_kind_i  (cmd_i.kind),
  .tr_valid_i  (trace_o.valid),
  .tr_ready_i  (trace_o.ready),
  .tr_op_i     (trace_o.trace_opcode),
  .tr_trap_i   (trace_o.fault_code),
  .tr_halt_i   (trace_o.halted_now)
);

>>> bench/tiny_vm_instruction_step_unit_if_note.sv
// Testbench-side channel helpers for the instruction step unit regression.
`timescale 1ns / 1ps
package tvm_tb_pkg;
  import tvm_pkg::*;

  // One request as the bench sees it.
  typedef struct {
    kind_e            kind;
    logic [SlotW-1:0] slot_index;
    logic [OpW-1:0]   op_code;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic [WordW-1:0] operand_c;
    logic [WordW-1:0] write_value;
  } request_t;

  // One trace entry as the bench sees it.
  typedef struct {
    logic [SlotW-1:0] pc;
    logic [OpW-1:0]   opcode;
    trap_e            trap;
    logic             halted;
    logic [HkW-1:0]   hk;
  } trace_t;
endpackage

>>> bench/tiny_vm_instruction_step_unit_test.sv
// Self-checking regression of the instruction step unit with a behavioral machine model.
`timescale 1ns / 1ps
module tiny_vm_instruction_step_unit_test;
  import tvm_pkg::*;
  import tvm_tb_pkg::*;

  localparam int unsigned ProgDepth = 1024;
  localparam int unsigned NumRegs   = 16;
  localparam int unsigned DataDepth = 256;
  localparam int unsigned HkEvery   = 64;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [LenW-1:0] cfg_wdata_i;

  tvm_cmd_if   cmd_bus ();
  tvm_trace_if trace_bus ();

  tiny_vm_instruction_step_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_bus.sink),
    .trace_o    (trace_bus.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Machine model state.
  slot_t            vm_prog [ProgDepth];
  logic [WordW-1:0] vm_regs [NumRegs];
  logic [WordW-1:0] vm_mem [DataDepth];
  logic [WordW-1:0] vm_pc;
  logic             vm_halted;
  int unsigned      vm_steps;
  logic [HkW-1:0]   vm_hk;
  logic [LenW-1:0]  vm_length;

  trace_t expected_traces [$];
  int     error_count;
  int     trace_count;
  int     trap_seen [4];
  bit     long_hold;

  function automatic logic addr_in_range(logic [WordW-1:0] v);
    return !v[WordW-1] && v < WordW'(DataDepth);
  endfunction

  function automatic logic [WordW-1:0] abs_value(logic [WordW-1:0] v);
    return v[WordW-1] ? -v : v;
  endfunction

  function automatic void clear_machine();
    foreach (vm_regs[i]) vm_regs[i] = '0;
    foreach (vm_mem[i]) vm_mem[i] = '0;
    vm_pc = '0;
    vm_halted = 1'b0;
    vm_steps = 0;
    vm_hk = '0;
  endfunction

  function automatic void push_trace(logic [WordW-1:0] pc, logic [OpW-1:0] op, trap_e trap);
    trace_t t;
    t.pc = pc[SlotW-1:0];
    t.opcode = op;
    t.trap = trap;
    t.halted = vm_halted;
    t.hk = vm_hk;
    expected_traces = {expected_traces, t};
  endfunction

  // Advances the model by one request and queues the trace entry it causes.
  function automatic void step_machine(request_t r);
    logic [WordW-1:0] limit, pc, lhs, rhs, q;
    slot_t s;
    limit = (vm_length > LenW'(ProgDepth)) ? WordW'(ProgDepth) : WordW'(vm_length);
    pc = vm_pc;
    case (r.kind)
      KIND_PROG: begin
        vm_prog[r.slot_index] = '{op: r.op_code, a: r.operand_a, b: r.operand_b,
                                  c: r.operand_c};
      end
      KIND_REG: if (r.slot_index < SlotW'(NumRegs)) vm_regs[r.slot_index] = r.write_value;
      KIND_RESTART: clear_machine();
      default: begin
        if (vm_halted) return;
        if (pc >= limit) begin
          push_trace(pc, OP_NOP, TRAP_DECODE);
          return;
        end
        s = vm_prog[pc];
        vm_steps++;
        if (vm_steps >= HkEvery) begin
          vm_steps = 0;
          vm_hk++;
        end
        case (s.op)
          OP_NOP: ;
          OP_HALT: vm_halted = 1'b1;
          OP_LOADIMM: vm_regs[s.a[3:0]] = s.b;
          OP_LOAD: begin
            if (!addr_in_range(s.b)) begin
              push_trace(pc, s.op, TRAP_DECODE);
              return;
            end
            vm_regs[s.a[3:0]] = vm_mem[s.b[7:0]];
          end
          OP_STORE: begin
            if (!addr_in_range(s.a)) begin
              push_trace(pc, s.op, TRAP_BOUNDS);
              return;
            end
            vm_mem[s.a[7:0]] = vm_regs[s.b[3:0]];
          end
          OP_DIV, OP_MOD: begin
            lhs = vm_regs[s.b[3:0]];
            rhs = vm_regs[s.c[3:0]];
            if (rhs == '0) begin
              push_trace(pc, s.op, TRAP_DIVISION);
              return;
            end
            if (s.op == OP_DIV) begin
              q = abs_value(lhs) / abs_value(rhs);
              if (lhs[WordW-1] != rhs[WordW-1]) q = -q;
            end else begin
              q = abs_value(lhs) % abs_value(rhs);
              if (lhs[WordW-1]) q = -q;
            end
            vm_regs[s.a[3:0]] = q;
          end
          OP_JUMP: begin
            vm_pc = s.a;
            push_trace(pc, s.op, TRAP_NONE);
            return;
          end
          default: begin
            push_trace(pc, s.op, TRAP_DECODE);
            return;
          end
        endcase
        vm_pc = pc + WordW'(1);
        push_trace(pc, s.op, TRAP_NONE);
      end
    endcase
  endfunction

  // Valid stays high after a transaction; it drops only for a gap or when the bus idles.
  task automatic send_request(request_t r);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.kind <= r.kind;
    cmd_bus.slot_index <= r.slot_index;
    cmd_bus.op_code <= r.op_code;
    cmd_bus.operand_a <= r.operand_a;
    cmd_bus.operand_b <= r.operand_b;
    cmd_bus.operand_c <= r.operand_c;
    cmd_bus.write_value <= r.write_value;
    do @(posedge clk_i); while (!cmd_bus.ready);
    step_machine(r);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    cmd_bus.valid <= 1'b0;
    while (expected_traces.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_length(logic [LenW-1:0] len);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vm_length = len;
  endtask

  function automatic logic [WordW-1:0] rand_word();
    logic [WordW-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: w = 64'h8000_0000_0000_0000;
      1: w = 64'h7fff_ffff_ffff_ffff;
      2: w = '1;
      3: w = '0;
      4: w = {{56{w[63]}}, w[7:0]};
      default: ;
    endcase
    return w;
  endfunction

  // Small addresses mostly, so loads and stores mostly land in range.
  function automatic logic [WordW-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0: return rand_word();
      1: return 64'd256 + $urandom_range(0, 3);
      2: return -64'($urandom_range(1, 3));
      default: return 64'($urandom_range(0, DataDepth - 1));
    endcase
  endfunction

  function automatic request_t rand_slot_write(int unsigned slot, int unsigned span);
    request_t r;
    int unsigned pick;
    r = '{KIND_PROG, slot[SlotW-1:0], '0, rand_word(), rand_word(), rand_word(), rand_word()};
    pick = $urandom_range(0, 99);
    if (pick < 3) r.op_code = OP_HALT;
    else if (pick < 8) r.op_code = 4'($urandom_range(8, 15));
    else if (pick < 12) r.op_code = OP_JUMP;
    else r.op_code = 4'($urandom_range(0, 6));
    if (r.op_code == OP_HALT && $urandom_range(0, 1)) r.op_code = OP_NOP;
    case (r.op_code)
      OP_LOAD: r.operand_b = rand_addr();
      OP_STORE: r.operand_a = rand_addr();
      OP_JUMP: if ($urandom_range(0, 7) != 0) r.operand_a = 64'($urandom_range(0, span - 1));
      default: ;
    endcase
    return r;
  endfunction

  // Directed rows; a zero-length program faults straight away.
  request_t directed_rows [$];
  trace_t   directed_want [$];
  bit       directed_fixed [$];

  task automatic add_row(request_t r, bit fixed, trace_t want);
    directed_rows = {directed_rows, r};
    directed_fixed = {directed_fixed, fixed};
    directed_want = {directed_want, want};
  endtask

  initial begin
    request_t r;
    trace_t none;
    int unsigned span;
    int unsigned len;
    int sent;
    bit held_once;
    error_count = 0;
    trace_count = 0;
    long_hold = 1'b0;
    held_once = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.kind = KIND_PROG;
    cmd_bus.slot_index = '0;
    cmd_bus.op_code = '0;
    cmd_bus.operand_a = '0;
    cmd_bus.operand_b = '0;
    cmd_bus.operand_c = '0;
    cmd_bus.write_value = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    foreach (vm_prog[i]) vm_prog[i] = '0;
    vm_length = '0;
    clear_machine();
    none = '{'0, '0, TRAP_NONE, 1'b0, '0};
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row('{KIND_EXEC, '0, '0, '0, '0, '0, '0}, 1'b1,
            '{10'd0, OP_NOP, TRAP_DECODE, 1'b0, 32'd0});
    add_row('{KIND_REG, 10'd1, '0, '0, '0, '0, 64'h8000_0000_0000_0000}, 1'b0, none);
    add_row('{KIND_REG, 10'd2, '0, '0, '0, '0, '1}, 1'b0, none);
    add_row('{KIND_REG, 10'd15, '0, '0, '0, '0, 64'h7fff_ffff_ffff_ffff}, 1'b0, none);
    add_row('{KIND_REG, 10'd1023, '0, '0, '0, '0, 64'd5}, 1'b0, none);
    add_row('{KIND_PROG, 10'd0, OP_DIV, 64'd3, 64'd1, 64'd2, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd1, OP_MOD, 64'd4, 64'h11, 64'd2, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd2, OP_DIV, 64'd5, 64'd1, 64'd0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd3, OP_STORE, 64'd255, 64'd15, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd4, OP_LOAD, 64'd6, 64'd255, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd5, OP_LOAD, 64'd6, -64'd1, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd6, OP_STORE, 64'd256, 64'd1, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd7, 4'd15, '0, '0, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd8, OP_LOADIMM, -64'd1, 64'h1234, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd9, OP_JUMP, 64'd11, '0, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd11, OP_HALT, '0, '0, '0, '0}, 1'b0, none);
    add_row('{KIND_PROG, 10'd1023, OP_JUMP, 64'h8000_0000_0000_0000, '0, '0, '0}, 1'b0,
            none);
    foreach (directed_rows[i]) begin
      if (i == 1) write_length(11'd12);
      send_request(directed_rows[i]);
      if (directed_fixed[i] && expected_traces.size() != 0) begin
        expected_traces.pop_back();
        expected_traces = {expected_traces, directed_want[i]};
      end
    end
    // Step the directed program; the zero divisor at slot 2 faults and then repeats.
    repeat (13) send_request('{KIND_EXEC, '0, '0, '0, '0, '0, '0});
    send_request('{KIND_RESTART, '0, '0, '0, '0, '0, '0});
    write_length(11'd1024);
    r = '{KIND_PROG, 10'd1022, OP_JUMP, 64'd1023, '0, '0, '0};
    send_request(r);
    send_request('{KIND_REG, '0, '0, '0, '0, '0, '0});
    r = '{KIND_PROG, 10'd0, OP_JUMP, 64'd1022, '0, '0, '0};
    send_request(r);
    repeat (4) send_request('{KIND_EXEC, '0, '0, '0, '0, '0, '0});
    write_length(11'h7ff);
    repeat (2) send_request('{KIND_EXEC, '0, '0, '0, '0, '0, '0});

    // Random phases: write a small program, restart, then run it with some noise.
    sent = 0;
    while (sent < 1500) begin
      span = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(2, 12);
      case ($urandom_range(0, 5))
        0: len = span - 1;
        1: len = span + $urandom_range(0, 3);
        default: len = span;
      endcase
      write_length(LenW'(len));
      // Every slot below the program length holds a written instruction.
      for (int unsigned i = 0; i < ((len > span) ? len : span); i++) begin
        send_request(rand_slot_write(i, span));
        sent++;
      end
      send_request('{KIND_RESTART, '0, '0, '0, '0, '0, '0});
      for (int k = 0; k < 4; k++) begin
        send_request('{KIND_REG, 10'($urandom_range(0, 17)), '0, '0, '0, '0, rand_word()});
        sent++;
      end
      if (!held_once || $urandom_range(0, 4) == 0) begin
        long_hold = 1'b1;
        held_once = 1'b1;
      end
      for (int k = 0; k < 3 * span + 4; k++) begin
        case ($urandom_range(0, 19))
          0: send_request('{KIND_REG, 10'($urandom_range(0, 1023)), '0, '0, '0, '0,
                            rand_word()});
          1: if ($urandom_range(0, 2) == 0)
               send_request('{KIND_RESTART, '0, '0, '0, '0, '0, '0});
          default: send_request('{KIND_EXEC, '0, '0, '0, '0, '0, '0});
        endcase
        sent++;
      end
    end
    wait_drained();
    $display("Covered %0d trace transactions over 1500+ requests; traps none/decode/bounds/div:",
             trace_count);
    $display("  %0d / %0d / %0d / %0d", trap_seen[0], trap_seen[1], trap_seen[2],
             trap_seen[3]);
    if (error_count == 0 && expected_traces.size() == 0) begin
      $display("tiny_vm_instruction_step_unit regression: pass");
    end else begin
      $display("tiny_vm_instruction_step_unit regression: fail");
    end
    $finish;
  end

  // Trace sink: random back-pressure, with one long hold-off when asked.
  initial begin
    int hold;
    trace_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        trace_bus.ready <= 1'b0;
        for (int i = 0; i < 600; i++) @(posedge clk_i);
      end
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) hold = 0;
      if (hold != 0) begin
        trace_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      trace_bus.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Checker: compares each trace transaction with the oldest expected entry.
  always @(posedge clk_i) begin
    trace_t want;
    if (rst_ni && trace_bus.valid && trace_bus.ready) begin
      trace_count++;
      if (expected_traces.size() == 0) begin
        $display("%0t: unexpected trace transaction pc=%0d op=%0d", $time,
                 trace_bus.trace_pc, trace_bus.trace_opcode);
        error_count++;
      end else begin
        want = expected_traces.pop_front();
        trap_seen[want.trap]++;
        if (trace_bus.trace_pc !== want.pc) begin
          $display("%0t: trace_pc expected %0d actual %0d", $time, want.pc,
                   trace_bus.trace_pc);
          error_count++;
        end
        if (trace_bus.trace_opcode !== want.opcode) begin
          $display("%0t: trace_opcode expected %0d actual %0d", $time, want.opcode,
                   trace_bus.trace_opcode);
          error_count++;
        end
        if (trace_bus.fault_code !== want.trap) begin
          $display("%0t: fault_code expected %0d actual %0d", $time, want.trap,
                   trace_bus.fault_code);
          error_count++;
        end
        if (trace_bus.halted_now !== want.halted) begin
          $display("%0t: halted_now expected %0b actual %0b", $time, want.halted,
                   trace_bus.halted_now);
          error_count++;
        end
        if (trace_bus.housekeeping_count !== want.hk) begin
          $display("%0t: housekeeping_count expected %0d actual %0d", $time, want.hk,
                   trace_bus.housekeeping_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("tiny_vm_instruction_step_unit regression: fail");
    $finish;
  end
endmodule

>>> files.f
hdl/tvm_pkg.sv
hdl/tvm_cmd_if.sv
hdl/tvm_trace_if.sv
hdl/tiny_vm_instruction_step_unit.sv
hdl/tvm_chk.sv
bench/tiny_vm_instruction_step_unit_if_note.sv
bench/tiny_vm_instruction_step_unit_test.sv
